FILE: sv/ttg_pkg.sv
// Shared types and constants for the tempo tick generator.
// Used by ttg_cfg, ttg_divider and tempo_tick_generator; depends on nothing.
package ttg_pkg;

    localparam int unsigned TIME_W    = 32;  // timestamp and elapsed-time width
    localparam int unsigned PERIOD_W  = 26;  // tick period width
    localparam int unsigned TICK_W    = 16;  // tick count width
    localparam int unsigned CFG_W     = 16;  // configuration data width
    localparam int unsigned CFG_IDX_W = 2;   // configuration index width
    localparam int unsigned SUM_W     = 17;  // positive tempo sum width
    localparam int unsigned DIV_CNT_W = $clog2(TIME_W + 1);

    localparam logic [TIME_W-1:0]   USEC_PER_MINUTE = TIME_W'(60000000);
    localparam logic [PERIOD_W-1:0] PERIOD_RESET    = PERIOD_W'(10416);
    localparam logic [CFG_W-1:0]    BPM_RESET       = CFG_W'(120);
    localparam logic [CFG_W-1:0]    ADJUST_RESET    = '0;
    localparam logic [CFG_W-1:0]    TPQ_RESET       = CFG_W'(48);
    localparam logic [TICK_W-1:0]   TICK_MAX        = '1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TEMPO_BPM    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMPO_ADJUST = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_Q  = 2'd2;

    typedef enum logic [1:0] {
        REQ_POLL    = 2'd0,
        REQ_RESTART = 2'd1,
        REQ_PAUSE   = 2'd2,
        REQ_RESUME  = 2'd3
    } req_t;

    // Configuration status toward the sequencer.
    typedef struct packed {
        logic              recalc;  // one-cycle pulse after a valid write
        logic              bad;     // latest write gave no valid period
        logic [SUM_W-1:0]  sum;     // tempo_bpm + tempo_adjust of the valid write
        logic [CFG_W-1:0]  tpq;     // ticks_per_quarter of the valid write
    } cfg_status_t;

    typedef struct packed {
        logic                start;
        logic [TIME_W-1:0]   dividend;
        logic [PERIOD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [TIME_W-1:0]   quotient;
        logic [PERIOD_W-1:0] remainder;
    } div_rsp_t;

endpackage

FILE: sv/ttg_divider.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on ttg_pkg for widths and the request and response structs.
module ttg_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  ttg_pkg::div_req_t req_i,
    output ttg_pkg::div_rsp_t rsp_o
);

    logic [ttg_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          done_reg;
    logic [ttg_pkg::TIME_W-1:0]    quo_reg;
    logic [ttg_pkg::PERIOD_W-1:0]  rem_reg;
    logic [ttg_pkg::PERIOD_W-1:0]  dsr_reg;

    logic [ttg_pkg::PERIOD_W:0]    trial;
    logic [ttg_pkg::PERIOD_W+1:0]  diff;

    // The dividend shifts out of the top of quo_reg while quotient bits enter at the bottom.
    assign trial = {rem_reg, quo_reg[ttg_pkg::TIME_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (req_i.start) begin
            cnt_reg  <= ttg_pkg::DIV_CNT_W'(ttg_pkg::TIME_W);
            done_reg <= 1'b0;
            quo_reg  <= req_i.dividend;
            rem_reg  <= '0;
            dsr_reg  <= req_i.divisor;
        end else begin
            done_reg <= (cnt_reg == ttg_pkg::DIV_CNT_W'(1));
            if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - ttg_pkg::DIV_CNT_W'(1);
                if (!diff[ttg_pkg::PERIOD_W+1]) begin
                    rem_reg <= diff[ttg_pkg::PERIOD_W-1:0];
                    quo_reg <= {quo_reg[ttg_pkg::TIME_W-2:0], 1'b1};
                end else begin
                    rem_reg <= trial[ttg_pkg::PERIOD_W-1:0];
                    quo_reg <= {quo_reg[ttg_pkg::TIME_W-2:0], 1'b0};
                end
            end
        end
    end

    assign rsp_o.done      = done_reg;
    assign rsp_o.quotient  = quo_reg;
    assign rsp_o.remainder = rem_reg;

endmodule

FILE: sv/ttg_cfg.sv
// Configuration registers, tempo validity check and snapshot of the operands
// for the period computation. Depends on ttg_pkg.
module ttg_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [ttg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ttg_pkg::CFG_W-1:0]      cfg_wdata,
    output ttg_pkg::cfg_status_t           status_o
);

    logic [ttg_pkg::CFG_W-1:0] bpm_reg;
    logic [ttg_pkg::CFG_W-1:0] adj_reg;
    logic [ttg_pkg::CFG_W-1:0] tpq_reg;
    logic                      bad_reg;
    logic                      recalc_reg;
    logic [ttg_pkg::SUM_W-1:0] sum_reg;
    logic [ttg_pkg::CFG_W-1:0] snap_tpq_reg;

    logic [ttg_pkg::CFG_W-1:0] bpm_next;
    logic [ttg_pkg::CFG_W-1:0] adj_next;
    logic [ttg_pkg::CFG_W-1:0] tpq_next;
    logic                      index_ok;
    logic [ttg_pkg::SUM_W:0]   sum_next;
    logic                      tempo_ok;

    always_comb begin
        bpm_next = bpm_reg;
        adj_next = adj_reg;
        tpq_next = tpq_reg;
        index_ok = 1'b1;
        unique case (cfg_index)
            ttg_pkg::CFG_TEMPO_BPM:    bpm_next = cfg_wdata;
            ttg_pkg::CFG_TEMPO_ADJUST: adj_next = cfg_wdata;
            ttg_pkg::CFG_TICKS_PER_Q:  tpq_next = cfg_wdata;
            default:                   index_ok = 1'b0;
        endcase
    end

    // Signed sum of the unsigned base and the signed adjustment, one guard bit for the sign.
    assign sum_next = {2'b00, bpm_next} + {{2{adj_next[ttg_pkg::CFG_W-1]}}, adj_next};
    assign tempo_ok = !sum_next[ttg_pkg::SUM_W] && (sum_next != '0) && (tpq_next != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpm_reg    <= ttg_pkg::BPM_RESET;
            adj_reg    <= ttg_pkg::ADJUST_RESET;
            tpq_reg    <= ttg_pkg::TPQ_RESET;
            bad_reg    <= 1'b0;
            recalc_reg <= 1'b0;
        end else begin
            recalc_reg <= cfg_we && index_ok && tempo_ok;
            if (cfg_we && index_ok) begin
                bpm_reg <= bpm_next;
                adj_reg <= adj_next;
                tpq_reg <= tpq_next;
                bad_reg <= !tempo_ok;
                if (tempo_ok) begin
                    sum_reg      <= sum_next[ttg_pkg::SUM_W-1:0];
                    snap_tpq_reg <= tpq_next;
                end
            end
        end
    end

    assign status_o.recalc = recalc_reg;
    assign status_o.bad    = bad_reg;
    assign status_o.sum    = sum_reg;
    assign status_o.tpq    = snap_tpq_reg;

endmodule

FILE: sv/tempo_tick_generator.sv
// Tempo tick generator top level: request sequencer, timekeeping state and result register.
// Depends on ttg_pkg, ttg_cfg and ttg_divider.
//
//  Port group   Direction  Handshake        Payload
//  s_*          in         s_valid/s_ready  s_req_type[1:0], s_now_us[31:0]
//  m_*          out        m_valid/m_ready  m_tick_count[15:0], m_is_paused, m_bad_tempo
//  cfg_*        in         cfg_we           cfg_index[1:0], cfg_wdata[15:0]
//
// A poll while running registers the elapsed time on acceptance and divides it by the
// period in the bit-serial divider. Restart, pause, resume and a poll while paused go
// straight to the result handoff. A valid configuration write while idle or computing the
// period recomputes it with two passes through the same divider, and no item is accepted
// until it finishes. Reset leaves the generator paused at 120 bpm and 48 ticks per quarter.
// A stalled result waits in the output register while the next item is already worked on.
module tempo_tick_generator (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_req_type,
    input  logic [ttg_pkg::TIME_W-1:0]     s_now_us,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [ttg_pkg::TICK_W-1:0]     m_tick_count,
    output logic                           m_is_paused,
    output logic                           m_bad_tempo,
    input  logic                           cfg_we,
    input  logic [ttg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ttg_pkg::CFG_W-1:0]      cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PER_DIV1,
        ST_PER_DIV2,
        ST_POLL_START,
        ST_POLL_DIV,
        ST_RESULT
    } state_t;

    state_t                       state_reg;
    logic                         paused_reg;
    logic [ttg_pkg::TIME_W-1:0]   baseline_reg;
    logic [ttg_pkg::TIME_W-1:0]   carried_reg;
    logic [ttg_pkg::PERIOD_W-1:0] period_reg;
    logic [ttg_pkg::TIME_W-1:0]   now_reg;
    logic [ttg_pkg::TIME_W-1:0]   elapsed_reg;
    logic [ttg_pkg::TICK_W-1:0]   ticks_reg;
    logic                         m_valid_reg;
    logic [ttg_pkg::TICK_W-1:0]   m_ticks_reg;
    logic                         m_paused_reg;
    logic                         m_bad_reg;

    ttg_pkg::cfg_status_t cfg_status;
    ttg_pkg::div_req_t    div_req;
    ttg_pkg::div_rsp_t    div_rsp;
    logic                 cfg_phase;

    ttg_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .status_o  (cfg_status)
    );

    ttg_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req_i   (div_req),
        .rsp_o   (div_rsp)
    );

    assign cfg_phase = (state_reg == ST_IDLE) || (state_reg == ST_PER_DIV1) ||
                       (state_reg == ST_PER_DIV2);

    // A fresh valid write restarts the period computation even if one is under way.
    always_comb begin
        div_req.start = (cfg_phase && cfg_status.recalc) ||
                        ((state_reg == ST_PER_DIV1) && div_rsp.done) ||
                        (state_reg == ST_POLL_START);
        if (cfg_status.recalc) begin
            div_req.dividend = ttg_pkg::USEC_PER_MINUTE;
            div_req.divisor  = ttg_pkg::PERIOD_W'(cfg_status.sum);
        end else if (state_reg == ST_PER_DIV1) begin
            div_req.dividend = div_rsp.quotient;
            div_req.divisor  = ttg_pkg::PERIOD_W'(cfg_status.tpq);
        end else begin
            div_req.dividend = elapsed_reg;
            div_req.divisor  = period_reg;
        end
    end

    assign s_ready = (state_reg == ST_IDLE) && !cfg_we && !cfg_status.recalc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            paused_reg   <= 1'b1;
            baseline_reg <= '0;
            carried_reg  <= '0;
            period_reg   <= ttg_pkg::PERIOD_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            // In ST_RESULT the result register is reloaded below instead.
            if (m_valid_reg && m_ready && (state_reg != ST_RESULT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (cfg_status.recalc) begin
                        state_reg <= ST_PER_DIV1;
                    end else if (s_valid && s_ready) begin
                        now_reg     <= s_now_us;
                        elapsed_reg <= carried_reg + s_now_us - baseline_reg;
                        ticks_reg   <= '0;
                        unique case (ttg_pkg::req_t'(s_req_type))
                            ttg_pkg::REQ_POLL: begin
                                if (!paused_reg) begin
                                    state_reg <= ST_POLL_START;
                                end else begin
                                    state_reg <= ST_RESULT;
                                end
                            end
                            ttg_pkg::REQ_RESTART: begin
                                baseline_reg <= s_now_us;
                                state_reg    <= ST_RESULT;
                            end
                            ttg_pkg::REQ_PAUSE: begin
                                paused_reg <= 1'b1;
                                state_reg  <= ST_RESULT;
                            end
                            ttg_pkg::REQ_RESUME: begin
                                paused_reg   <= 1'b0;
                                baseline_reg <= s_now_us;
                                state_reg    <= ST_RESULT;
                            end
                            default: state_reg <= ST_RESULT;
                        endcase
                    end
                end
                ST_PER_DIV1: begin
                    if (!cfg_status.recalc && div_rsp.done) begin
                        state_reg <= ST_PER_DIV2;
                    end
                end
                ST_PER_DIV2: begin
                    if (cfg_status.recalc) begin
                        state_reg <= ST_PER_DIV1;
                    end else if (div_rsp.done) begin
                        // A period that rounds down to zero runs at one microsecond.
                        if (div_rsp.quotient == '0) begin
                            period_reg <= ttg_pkg::PERIOD_W'(1);
                        end else begin
                            period_reg <= div_rsp.quotient[ttg_pkg::PERIOD_W-1:0];
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                ST_POLL_START: begin
                    state_reg <= ST_POLL_DIV;
                end
                ST_POLL_DIV: begin
                    if (div_rsp.done) begin
                        // Less than one period elapsed leaves all timekeeping state alone.
                        if (div_rsp.quotient != '0) begin
                            carried_reg  <= ttg_pkg::TIME_W'(div_rsp.remainder);
                            baseline_reg <= now_reg;
                            if (div_rsp.quotient[ttg_pkg::TIME_W-1:ttg_pkg::TICK_W] != '0) begin
                                ticks_reg <= ttg_pkg::TICK_MAX;
                            end else begin
                                ticks_reg <= div_rsp.quotient[ttg_pkg::TICK_W-1:0];
                            end
                        end
                        state_reg <= ST_RESULT;
                    end
                end
                ST_RESULT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_ticks_reg  <= ticks_reg;
                        m_paused_reg <= paused_reg;
                        m_bad_reg    <= cfg_status.bad;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_tick_count = m_ticks_reg;
    assign m_is_paused  = m_paused_reg;
    assign m_bad_tempo  = m_bad_reg;

endmodule
